// ===== src/seven_segment_scan_shift_driver_core_macros.svh =====
// Assertion macros shared by the checker.
`ifndef SEVEN_SEGMENT_SCAN_SHIFT_DRIVER_CORE_MACROS_SVH
`define SEVEN_SEGMENT_SCAN_SHIFT_DRIVER_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SSD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/ssd_pkg.sv =====
package ssd_pkg;

  localparam int unsigned Digits = 16;
  localparam int unsigned DigitW = $clog2(Digits);
  localparam int unsigned SegW   = 8;
  localparam int unsigned WordW  = 32;
  localparam int unsigned BitCntW = 6;
  localparam int unsigned DwellW = 16;
  localparam logic [DwellW-1:0] DwellReset = 16'd166;
  localparam logic [SegW-1:0] SegBlank = 8'hFF;

  localparam logic [1:0] PH_LOAD  = 2'd0;
  localparam logic [1:0] PH_SHIFT = 2'd1;
  localparam logic [1:0] PH_LATCH = 2'd2;
  localparam logic [1:0] PH_DWELL = 2'd3;

  localparam logic [BitCntW-1:0] BitCntLast = 6'd63;

  // Pin levels and scanned digit as seen after one item.
  typedef struct packed {
    logic              serial_data;
    logic              shift_clock;
    logic              latch_clock;
    logic [DigitW-1:0] current_digit;
  } scan_pins_t;

  // Low digits use the upper half of the chain, high digits the lower half.
  function automatic logic [WordW-1:0] build_word(logic [SegW-1:0] seg,
                                                  logic [DigitW-1:0] d);
    logic [7:0] col;
    col = 8'b1 << d[2:0];
    if (!d[3]) begin
      return {seg, col, 16'h0000};
    end
    return {16'h0000, seg, col};
  endfunction

endpackage

// ===== src/seven_segment_scan_shift_driver_core.sv =====
// Scan driver for sixteen multiplexed seven-segment digits behind four
// chained serial-in shift registers with an output latch.
// Input channel (in_valid/in_ready): each item is either a tick
// (in_action = 0), which moves the data, shift clock and latch pins by one
// phase, or a write (in_action = 1), which stores in_segments for digit
// in_digit_index. A write leaves the pins as they are.
// Result channel (out_valid/out_ready): exactly one item per input item,
// carrying the pin levels and the scanned digit after that input item.
// Configuration: cfg_wr_en with cfg_wr_data sets the dwell length in ticks
// that follows each latch pulse; it takes effect at the next latch.
// An accepted item is loaded into the input register, and the scan logic
// then fills the result register from it, unless a stalled result still
// occupies it. Throughput is one item per cycle while out_ready stays high.
// When the receiver stalls, the input register still takes one more item,
// then in_ready drops until the result is taken.
// Reset (rst_n low, synchronous) blanks all digits to 0xFF, restarts the scan
// at digit 0 with data and shift clock low and latch high, sets the dwell to
// 166 ticks and empties both registers.
module seven_segment_scan_shift_driver_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_action,
  input  logic [ssd_pkg::DigitW-1:0] in_digit_index,
  input  logic [ssd_pkg::SegW-1:0]   in_segments,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_serial_data,
  output logic                       out_shift_clock,
  output logic                       out_latch_clock,
  output logic [ssd_pkg::DigitW-1:0] out_current_digit,
  input  logic                       cfg_wr_en,
  input  logic [ssd_pkg::DwellW-1:0] cfg_wr_data
);
  import ssd_pkg::*;

  // Input register.
  logic              s1_valid_r;
  logic              s1_action_r;
  logic [DigitW-1:0] s1_index_r;
  logic [SegW-1:0]   s1_seg_r;

  // Result register.
  logic       out_valid_r;
  scan_pins_t out_pins_r;

  logic [DwellW-1:0] dwell_ticks_r;

  logic              s1_go;
  logic [DigitW-1:0] scan_digit;
  logic [SegW-1:0]   seg_data;
  scan_pins_t        pins_nxt;

  // The item in the input register moves on whenever the result slot is free
  // or being emptied in this cycle.
  assign s1_go    = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_action_r <= in_action;
      s1_index_r  <= in_digit_index;
      s1_seg_r    <= in_segments;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dwell_ticks_r <= DwellReset;
    end else if (cfg_wr_en) begin
      dwell_ticks_r <= cfg_wr_data;
    end
  end

  ssd_digit_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (s1_go && s1_action_r),
    .wr_addr (s1_index_r),
    .wr_data (s1_seg_r),
    .rd_addr (scan_digit),
    .rd_data (seg_data)
  );

  ssd_scan_engine u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .tick        (s1_go && !s1_action_r),
    .dwell_ticks (dwell_ticks_r),
    .seg_data    (seg_data),
    .scan_digit  (scan_digit),
    .pins_nxt    (pins_nxt)
  );

  // The result register starts at the reset pin levels so that the outputs
  // never show unknown values.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      out_pins_r  <= '{serial_data: 1'b0, shift_clock: 1'b0,
                       latch_clock: 1'b1, current_digit: '0};
    end else if (s1_go) begin
      out_valid_r <= 1'b1;
      out_pins_r  <= pins_nxt;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_serial_data   = out_pins_r.serial_data;
  assign out_shift_clock   = out_pins_r.shift_clock;
  assign out_latch_clock   = out_pins_r.latch_clock;
  assign out_current_digit = out_pins_r.current_digit;

endmodule

// ===== src/ssd_digit_store.sv =====
module ssd_digit_store (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       wr_en,
  input  logic [ssd_pkg::DigitW-1:0] wr_addr,
  input  logic [ssd_pkg::SegW-1:0]   wr_data,
  input  logic [ssd_pkg::DigitW-1:0] rd_addr,
  output logic [ssd_pkg::SegW-1:0]   rd_data
);
  import ssd_pkg::*;

  logic [SegW-1:0] store_r [Digits];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < Digits; i++) begin
        store_r[i] <= SegBlank;
      end
    end else if (wr_en) begin
      store_r[wr_addr] <= wr_data;
    end
  end

  assign rd_data = store_r[rd_addr];

endmodule

// ===== src/ssd_scan_engine.sv =====
module ssd_scan_engine (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       tick,
  input  logic [ssd_pkg::DwellW-1:0] dwell_ticks,
  input  logic [ssd_pkg::SegW-1:0]   seg_data,
  output logic [ssd_pkg::DigitW-1:0] scan_digit,
  output ssd_pkg::scan_pins_t        pins_nxt
);
  import ssd_pkg::*;

  logic [WordW-1:0]   word_r,  word_nxt;
  logic [DigitW-1:0]  pos_r,   pos_nxt;
  logic [BitCntW-1:0] bcnt_r,  bcnt_nxt;
  logic [1:0]         phase_r, phase_nxt;
  logic [DwellW-1:0]  dwell_r, dwell_nxt;
  logic               data_r,  data_nxt;
  logic               sclk_r,  sclk_nxt;
  logic               latch_r, latch_nxt;

  always_comb begin
    word_nxt  = word_r;
    pos_nxt   = pos_r;
    bcnt_nxt  = bcnt_r;
    phase_nxt = phase_r;
    dwell_nxt = dwell_r;
    data_nxt  = data_r;
    sclk_nxt  = sclk_r;
    latch_nxt = latch_r;
    if (tick) begin
      case (phase_r)
        PH_LOAD: begin
          word_nxt  = build_word(seg_data, pos_r);
          bcnt_nxt  = '0;
          phase_nxt = PH_SHIFT;
        end
        PH_SHIFT: begin
          if (!bcnt_r[0]) begin
            data_nxt = word_r[WordW-1];
            sclk_nxt = 1'b0;
          end else begin
            sclk_nxt = 1'b1;
            word_nxt = {word_r[WordW-2:0], 1'b0};
          end
          if (bcnt_r == BitCntLast) begin
            bcnt_nxt  = '0;
            phase_nxt = PH_LATCH;
          end else begin
            bcnt_nxt = bcnt_r + 6'd1;
          end
        end
        PH_LATCH: begin
          if (bcnt_r == '0) begin
            latch_nxt = 1'b0;
            bcnt_nxt  = 6'd1;
          end else begin
            latch_nxt = 1'b1;
            bcnt_nxt  = '0;
            dwell_nxt = dwell_ticks;
            if (dwell_ticks == '0) begin
              pos_nxt   = pos_r + 4'd1;
              phase_nxt = PH_LOAD;
            end else begin
              phase_nxt = PH_DWELL;
            end
          end
        end
        default: begin
          // The tick that would reach zero moves on to the next digit.
          if (dwell_r[DwellW-1:1] == '0) begin
            dwell_nxt = '0;
            pos_nxt   = pos_r + 4'd1;
            phase_nxt = PH_LOAD;
          end else begin
            dwell_nxt = dwell_r - 16'd1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r  <= '0;
      pos_r   <= '0;
      bcnt_r  <= '0;
      phase_r <= PH_LOAD;
      dwell_r <= '0;
      data_r  <= 1'b0;
      sclk_r  <= 1'b0;
      latch_r <= 1'b1;
    end else begin
      word_r  <= word_nxt;
      pos_r   <= pos_nxt;
      bcnt_r  <= bcnt_nxt;
      phase_r <= phase_nxt;
      dwell_r <= dwell_nxt;
      data_r  <= data_nxt;
      sclk_r  <= sclk_nxt;
      latch_r <= latch_nxt;
    end
  end

  assign scan_digit             = pos_r;
  assign pins_nxt.serial_data   = data_nxt;
  assign pins_nxt.shift_clock   = sclk_nxt;
  assign pins_nxt.latch_clock   = latch_nxt;
  assign pins_nxt.current_digit = pos_nxt;

endmodule

// ===== src/ssd_checker.sv =====
`include "seven_segment_scan_shift_driver_core_macros.svh"

module ssd_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       out_shift_clock,
  input logic                       out_latch_clock,
  input logic [ssd_pkg::DigitW-1:0] out_current_digit
);

  // A stalled result holds its value.
  `SSD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_current_digit) && $stable(out_latch_clock),
    "result changed while stalled")

  // The latch only pulses low after the last shift clock edge, which is high.
  `SSD_ASSERT_NOW(a_latch_after_clock, out_valid && !out_latch_clock,
    out_shift_clock, "latch low while shift clock low")

  // The scanned digit moves on only with the latch high.
  `SSD_ASSERT_NOW(a_digit_step, out_valid &&
    (out_current_digit != $past(out_current_digit)),
    out_latch_clock, "digit advanced with latch low")

endmodule

bind seven_segment_scan_shift_driver_core ssd_checker u_ssd_checker (.*);

// ===== dv/ssd_scan_checker.sv =====
module ssd_scan_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic                       in_action,
  input  logic [ssd_pkg::DigitW-1:0] in_digit_index,
  input  logic [ssd_pkg::SegW-1:0]   in_segments,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic                       out_serial_data,
  input  logic                       out_shift_clock,
  input  logic                       out_latch_clock,
  input  logic [ssd_pkg::DigitW-1:0] out_current_digit,
  input  logic                       cfg_wr_en,
  input  logic [ssd_pkg::DwellW-1:0] cfg_wr_data,
  output int unsigned                mismatch_count,
  output int unsigned                pins_pending
);
  import ssd_pkg::*;

  localparam int unsigned ReportLimit = 10;

  // Local copy of the scan state, stepped once per accepted item.
  logic [SegW-1:0]    seg_store [Digits];
  logic [WordW-1:0]   chain_word;
  logic [DigitW-1:0]  scan_digit;
  logic [BitCntW-1:0] half_bits;
  logic [1:0]         scan_phase;
  logic [DwellW-1:0]  dwell_left;
  logic [DwellW-1:0]  dwell_setting;
  logic               pin_data;
  logic               pin_sclk;
  logic               pin_latch;

  scan_pins_t  pins_due [$];
  int unsigned miss_total = 0;

  // Applies one item to the local state and returns the pins it leaves.
  function automatic scan_pins_t predict_pins(input logic is_write,
                                              input logic [DigitW-1:0] idx,
                                              input logic [SegW-1:0] seg);
    logic [7:0] column;
    scan_pins_t pins;
    if (is_write) begin
      seg_store[idx] = seg;
    end else begin
      case (scan_phase)
        PH_LOAD: begin
          column = 8'd1 << scan_digit[2:0];
          if (scan_digit[DigitW-1]) begin
            chain_word = {16'h0000, seg_store[scan_digit], column};
          end else begin
            chain_word = {seg_store[scan_digit], column, 16'h0000};
          end
          half_bits = '0;
          scan_phase = PH_SHIFT;
        end
        PH_SHIFT: begin
          if (!half_bits[0]) begin
            pin_data = chain_word[WordW-1];
            pin_sclk = 1'b0;
          end else begin
            pin_sclk = 1'b1;
            chain_word = chain_word << 1;
          end
          if (half_bits == BitCntLast) begin
            half_bits = '0;
            scan_phase = PH_LATCH;
          end else begin
            half_bits = half_bits + 6'd1;
          end
        end
        PH_LATCH: begin
          if (half_bits == '0) begin
            pin_latch = 1'b0;
            half_bits = 6'd1;
          end else begin
            pin_latch = 1'b1;
            half_bits = '0;
            dwell_left = dwell_setting;
            if (dwell_setting == '0) begin
              scan_digit = scan_digit + 4'd1;
              scan_phase = PH_LOAD;
            end else begin
              scan_phase = PH_DWELL;
            end
          end
        end
        default: begin
          if (dwell_left <= 16'd1) begin
            dwell_left = '0;
            scan_digit = scan_digit + 4'd1;
            scan_phase = PH_LOAD;
          end else begin
            dwell_left = dwell_left - 16'd1;
          end
        end
      endcase
    end
    pins.serial_data = pin_data;
    pins.shift_clock = pin_sclk;
    pins.latch_clock = pin_latch;
    pins.current_digit = scan_digit;
    return pins;
  endfunction

  always @(posedge clk) begin
    scan_pins_t seen;
    scan_pins_t want;
    if (!rst_n) begin
      for (int d = 0; d < Digits; d++) begin
        seg_store[d] = SegBlank;
      end
      chain_word = '0;
      scan_digit = '0;
      half_bits = '0;
      scan_phase = PH_LOAD;
      dwell_left = '0;
      dwell_setting = DwellReset;
      pin_data = 1'b0;
      pin_sclk = 1'b0;
      pin_latch = 1'b1;
      pins_due.delete();
    end else begin
      if (cfg_wr_en) begin
        dwell_setting = cfg_wr_data;
      end
      if (in_valid && in_ready) begin
        pins_due.push_back(predict_pins(in_action, in_digit_index, in_segments));
      end
      if (out_valid && out_ready) begin
        seen.serial_data = out_serial_data;
        seen.shift_clock = out_shift_clock;
        seen.latch_clock = out_latch_clock;
        seen.current_digit = out_current_digit;
        if (pins_due.size() == 0) begin
          miss_total++;
          if (miss_total <= ReportLimit) begin
            $display("unexpected result: data %b sclk %b latch %b digit %0d",
                     seen.serial_data, seen.shift_clock, seen.latch_clock,
                     seen.current_digit);
          end
        end else begin
          want = pins_due.pop_front();
          if ((seen.serial_data !== want.serial_data) ||
              (seen.shift_clock !== want.shift_clock) ||
              (seen.latch_clock !== want.latch_clock) ||
              (seen.current_digit !== want.current_digit)) begin
            miss_total++;
            if (miss_total <= ReportLimit) begin
              $display("pin mismatch: expected data %b sclk %b latch %b digit %0d",
                       want.serial_data, want.shift_clock, want.latch_clock,
                       want.current_digit);
              $display("                   got data %b sclk %b latch %b digit %0d",
                       seen.serial_data, seen.shift_clock, seen.latch_clock,
                       seen.current_digit);
            end
          end
        end
      end
    end
    pins_pending <= pins_due.size();
    mismatch_count <= miss_total;
  end

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
  import ssd_pkg::*;

  // Meaning of in_action for one item.
  localparam logic ItemTick  = 1'b0;
  localparam logic ItemWrite = 1'b1;

  // Longest stretch that a correct run can take is well under a tenth of this.
  localparam int unsigned RunLimit = 5_000_000;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              in_action = ItemTick;
  logic [DigitW-1:0] in_digit_index = '0;
  logic [SegW-1:0]   in_segments = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              out_serial_data;
  logic              out_shift_clock;
  logic              out_latch_clock;
  logic [DigitW-1:0] out_current_digit;
  logic              cfg_wr_en = 1'b0;
  logic [DwellW-1:0] cfg_wr_data = '0;

  int unsigned mismatch_count;
  int unsigned pins_pending;

  // Idle bursts are switched off for the final part of the run.
  bit          tx_gaps_on = 1'b1;
  bit          rx_stalls_on = 1'b1;
  int unsigned rx_hold = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  seven_segment_scan_shift_driver_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_action         (in_action),
    .in_digit_index    (in_digit_index),
    .in_segments       (in_segments),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_serial_data   (out_serial_data),
    .out_shift_clock   (out_shift_clock),
    .out_latch_clock   (out_latch_clock),
    .out_current_digit (out_current_digit),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data)
  );

  ssd_scan_checker u_pins_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_action         (in_action),
    .in_digit_index    (in_digit_index),
    .in_segments       (in_segments),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_serial_data   (out_serial_data),
    .out_shift_clock   (out_shift_clock),
    .out_latch_clock   (out_latch_clock),
    .out_current_digit (out_current_digit),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .mismatch_count    (mismatch_count),
    .pins_pending      (pins_pending)
  );

  // Result side: out_ready is high except for random stall bursts. Each step
  // makes exactly one assignment to out_ready.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b1;
      rx_hold <= 0;
    end else if (rx_hold != 0) begin
      out_ready <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else if (rx_stalls_on && ($urandom_range(0, 9) == 0)) begin
      out_ready <= 1'b0;
      rx_hold <= $urandom_range(0, 14);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Offers one item and returns at the edge where it was accepted. Now and
  // then an idle gap goes before the item. When no gap is taken, in_valid
  // simply stays high into the next item.
  task automatic push_item(input logic act, input logic [DigitW-1:0] idx,
                           input logic [SegW-1:0] seg);
    int unsigned gap;
    if (tx_gaps_on && ($urandom_range(0, 7) == 0)) begin
      gap = $urandom_range(1, 15);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_digit_index <= idx;
    in_segments <= seg;
    do @(posedge clk); while (!in_ready);
  endtask

  // Mostly ticks, so the scan keeps moving, with writes to random digits
  // sprinkled in. The digit and segment fields are random on ticks too,
  // where the block has to ignore them.
  task automatic run_random(input int unsigned count, input int unsigned write_pct);
    logic act;
    for (int unsigned n = 0; n < count; n++) begin
      act = ($urandom_range(0, 99) < write_pct) ? ItemWrite : ItemTick;
      push_item(act, DigitW'($urandom_range(0, Digits - 1)), SegW'($urandom));
    end
  endtask

  // Stops sending and waits until every predicted result has come back, then
  // lets the two-stage pipeline settle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pins_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // The dwell register is only written while the pipeline is empty.
  task automatic write_dwell(input logic [DwellW-1:0] ticks);
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= ticks;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, at the reset dwell. Segment bytes 0x00, 0x80 and 0x7F go
    // into the first and last digit of each half of the chain.
    push_item(ItemWrite, 4'd0, 8'h00);
    push_item(ItemWrite, 4'd7, 8'h80);
    push_item(ItemWrite, 4'd8, 8'h7F);
    push_item(ItemWrite, 4'd15, 8'h00);
    // The first tick loads the word for digit 0. Overwriting digit 0 right
    // after must not change the word that is already being shifted, so the
    // segment bits that follow still come out as zeros.
    push_item(ItemTick, 4'd0, 8'h00);
    push_item(ItemWrite, 4'd0, 8'hFF);
    repeat (16) push_item(ItemTick, 4'd15, 8'hFF);

    // Zero dwell: every latch-high tick moves straight on to the next digit.
    // This runs across two digit boundaries.
    write_dwell('0);
    run_random(150, 6);

    // Shortest nonzero dwell, then a random moderate one.
    write_dwell(16'd1);
    run_random(40, 8);
    write_dwell(DwellW'($urandom_range(2, 40)));
    run_random(40, 10);

    // Final part without idling on either side. With the longest dwell the
    // scan finishes any running dwell and its next digit and parks in the
    // dwell phase within about a hundred and ten ticks. Changing the register
    // there must leave the running dwell alone.
    tx_gaps_on = 1'b0;
    rx_stalls_on <= 1'b0;
    write_dwell(16'hFFFF);
    run_random(110, 0);
    write_dwell('0);
    run_random(30, 10);

    wait_drained();
    repeat (8) @(posedge clk);
    if ((mismatch_count == 0) && (pins_pending == 0)) begin
      $display("PASS seven_segment_scan_shift_driver_core");
    end else begin
      $display("FAIL seven_segment_scan_shift_driver_core");
    end
    $finish;
  end

  initial begin
    #(RunLimit);
    $display("FAIL seven_segment_scan_shift_driver_core");
    $finish;
  end

endmodule
